// ----- design/preemptive_priority_scheduler_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler core
// These macros wrap concurrent assertions clocked on clk and muted while
// rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PPSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define PPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ppsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Transaction types, slot record, operation codes and controller states.
// ----------------------------------------------------------------------------
package ppsc_pkg;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  slot;
        logic [7:0]  job_id;
        logic [15:0] work;
        logic [7:0]  priority_req;
        logic [31:0] arrival;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  ran_id;
        logic [3:0]  ran_slot;
        logic        idle;
        logic [31:0] tick_time;
        logic        finished;
        logic        all_done;
    } out_item_t;

    // One entry of the slot memory.
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [31:0] arrival;
        logic [15:0] remaining;
    } slot_rec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Control from the sequencer to the pick unit.
    typedef struct packed {
        logic clear;
        logic eval;
        logic eval_complete;
    } pick_ctrl_t;

    // Status from the pick unit back to the sequencer.
    typedef struct packed {
        logic      found;
        logic [1:0] incomplete_cnt;
        slot_rec_t best_rec;
    } pick_status_t;

endpackage

// ----- design/ppsc_slot_mem.sv -----
// ----------------------------------------------------------------------------
// Slot memory
// Synchronous single write, single read store of slot records, with
// registered read data.
// ----------------------------------------------------------------------------
module ppsc_slot_mem #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(NUM_SLOTS)-1:0] waddr,
    input  ppsc_pkg::slot_rec_t          wdata,
    input  logic                         re,
    input  logic [$clog2(NUM_SLOTS)-1:0] raddr,
    output ppsc_pkg::slot_rec_t          rdata
);
    import ppsc_pkg::*;

    slot_rec_t mem [NUM_SLOTS];
    slot_rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/ppsc_pick.sv -----
// ----------------------------------------------------------------------------
// Pick unit
// Compares one slot record a cycle against the best candidate so far and
// counts the incomplete slots seen during the scan, saturating at two.
// ----------------------------------------------------------------------------
module ppsc_pick #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ppsc_pkg::pick_ctrl_t         ctrl,
    input  logic [$clog2(NUM_SLOTS)-1:0] eval_idx,
    input  ppsc_pkg::slot_rec_t          rec,
    input  logic [31:0]                  start_time,
    output ppsc_pkg::pick_status_t       status,
    output logic [$clog2(NUM_SLOTS)-1:0] best_idx
);
    import ppsc_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic             found_reg, found_next;
    logic [1:0]       inc_reg, inc_next;
    slot_rec_t        best_rec_reg, best_rec_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             cand;

    // Strictly greater priority is needed to displace, so ties keep the lower slot.
    assign cand = !ctrl.eval_complete && (rec.arrival <= start_time) &&
                  (!found_reg || (rec.prio > best_rec_reg.prio));

    always_comb
    begin
        found_next    = found_reg;
        inc_next      = inc_reg;
        best_rec_next = best_rec_reg;
        best_idx_next = best_idx_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
            inc_next   = 2'd0;
        end
        else if (ctrl.eval)
        begin
            if (cand)
            begin
                found_next    = 1'b1;
                best_rec_next = rec;
                best_idx_next = eval_idx;
            end
            if (!ctrl.eval_complete && (inc_reg != 2'd2))
            begin
                inc_next = inc_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            inc_reg   <= 2'd0;
        end
        else
        begin
            found_reg <= found_next;
            inc_reg   <= inc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_rec_reg <= best_rec_next;
        best_idx_reg <= best_idx_next;
    end

    assign status.found          = found_reg;
    assign status.incomplete_cnt = inc_reg;
    assign status.best_rec       = best_rec_reg;
    assign best_idx              = best_idx_reg;

endmodule

// ----- design/preemptive_priority_scheduler_core.sv -----
// Load and restart are done in the idle state without leaving it. A tick scans live slots, where
// live is active_count capped at NUM_SLOTS; the scan reads the slot memory one entry a cycle.
// The next transaction is taken only once the result is registered and the controller is back
// in idle, so a new tick is never taken before the last one is through, and a finished scan waits
// in the finish state while a waiting result is stalled.
// Reset clears the time counter, completion marks, active_count and handshake state at once.
// ----------------------------------------------------------------------------
// Preemptive priority scheduler core
// Job slot table in a synchronous memory, scanned once per tick to pick the
// highest priority eligible job, whose remaining work is then written back.
// The slot memory itself is not cleared by reset.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_core #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ppsc_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ppsc_pkg::out_item_t  out_item,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata
);
    import ppsc_pkg::*;
    `include "preemptive_priority_scheduler_core_defines.svh"

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    // Controller state.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;
    logic [31:0]        time_reg, time_next;
    logic [NUM_SLOTS-1:0] cmp_reg, cmp_next;
    logic [4:0]         active_count_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    // Handshake and sequencing strobes.
    logic               accept;
    logic               issue;
    logic               scan_end;
    logic               out_free;
    logic               commit;
    logic               slot_ok;
    logic [CNT_W-1:0]   live_cap;

    // Memory ports.
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    slot_rec_t          mem_wdata;
    slot_rec_t          mem_rdata;

    // Pick unit interface.
    pick_ctrl_t         pick_ctrl;
    pick_status_t       pick_status;
    logic [IDX_W-1:0]   best_idx;

    // Write-back values for the chosen slot.
    logic               fin;
    logic [15:0]        rem_dec;
    out_item_t          result;

    // ------------------------------------------------------------------------
    // Strobes. Only the idle state takes a transaction, so the scan never
    // sees a memory write in flight and the write-back in the finish state
    // has retired before the next tick can read the same entry.
    // ------------------------------------------------------------------------
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        accept   = in_valid && !in_stall;
        issue    = (state_reg == ST_SCAN) && (scan_idx_reg < live_reg);
        scan_end = (state_reg == ST_SCAN) && !issue && !rd_pend_reg;
        out_free = !out_valid_reg || !out_stall;
        commit   = (state_reg == ST_FINISH) && out_free;
        slot_ok  = (32'(in_item.slot) < NUM_SLOTS);
        if (32'(active_count_reg) > NUM_SLOTS)
        begin
            live_cap = CNT_W'(NUM_SLOTS);
        end
        else
        begin
            live_cap = CNT_W'(active_count_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_item.func == FUNC_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath outputs: scan counters, memory access, completion marks, time.
    // A picked slot with one or no work left drops to zero and is marked
    // complete; restart does not restore work, so such a slot can finish
    // again on a later tick.
    // ------------------------------------------------------------------------
    always_comb
    begin
        fin     = pick_status.found && (pick_status.best_rec.remaining <= 16'd1);
        rem_dec = (pick_status.best_rec.remaining > 16'd1) ?
                  (pick_status.best_rec.remaining - 16'd1) : 16'd0;

        scan_idx_next = scan_idx_reg;
        live_next     = live_reg;
        rd_pend_next  = issue;
        eval_idx_next = eval_idx_reg;
        time_next     = time_reg;
        cmp_next      = cmp_reg;

        mem_we              = 1'b0;
        mem_waddr           = IDX_W'(in_item.slot);
        mem_wdata.id        = in_item.job_id;
        mem_wdata.prio      = in_item.priority_req;
        mem_wdata.arrival   = in_item.arrival;
        mem_wdata.remaining = in_item.work;

        pick_ctrl.clear         = 1'b0;
        pick_ctrl.eval          = rd_pend_reg;
        pick_ctrl.eval_complete = cmp_reg[eval_idx_reg];

        if (accept)
        begin
            case (in_item.func)
                FUNC_LOAD:
                begin
                    if (slot_ok)
                    begin
                        mem_we = 1'b1;
                        cmp_next[IDX_W'(in_item.slot)] = (in_item.work == 16'd0);
                    end
                end
                FUNC_TICK:
                begin
                    scan_idx_next   = '0;
                    live_next       = live_cap;
                    pick_ctrl.clear = 1'b1;
                end
                FUNC_RESTART:
                begin
                    time_next = 32'd0;
                    cmp_next  = '0;
                end
                default:
                begin
                    // The unused code is swallowed without effect.
                end
            endcase
        end

        if (issue)
        begin
            eval_idx_next = scan_idx_reg[IDX_W-1:0];
            scan_idx_next = CNT_W'(scan_idx_reg + 1'b1);
        end

        if (commit)
        begin
            time_next = time_reg + 32'd1;
            if (pick_status.found)
            begin
                mem_we              = 1'b1;
                mem_waddr           = best_idx;
                mem_wdata           = pick_status.best_rec;
                mem_wdata.remaining = rem_dec;
            end
            if (fin)
            begin
                cmp_next[best_idx] = 1'b1;
            end
        end

        // The only slot that can change is the picked one, and only towards
        // complete, so everything is done once no other incomplete slot was
        // seen and the picked one has just finished.
        result.ran_id    = pick_status.found ? pick_status.best_rec.id : 8'd0;
        result.ran_slot  = pick_status.found ? 4'(best_idx) : 4'd0;
        result.idle      = !pick_status.found;
        result.tick_time = time_reg;
        result.finished  = fin;
        result.all_done  = (pick_status.incomplete_cnt == 2'd0) ||
                           ((pick_status.incomplete_cnt == 2'd1) && fin);
    end

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_idx_reg     <= '0;
            live_reg         <= '0;
            rd_pend_reg      <= 1'b0;
            eval_idx_reg     <= '0;
            time_reg         <= 32'd0;
            cmp_reg          <= '0;
            active_count_reg <= 5'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            live_reg     <= live_next;
            rd_pend_reg  <= rd_pend_next;
            eval_idx_reg <= eval_idx_next;
            time_reg     <= time_next;
            cmp_reg      <= cmp_next;
            if (cfg_we)
            begin
                active_count_reg <= cfg_wdata;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result register is payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ------------------------------------------------------------------------
    // Slot memory and pick unit.
    // ------------------------------------------------------------------------
    ppsc_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    ppsc_pick #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (pick_ctrl),
        .eval_idx   (eval_idx_reg),
        .rec        (mem_rdata),
        .start_time (time_reg),
        .status     (pick_status),
        .best_idx   (best_idx)
    );

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `PPSC_ASSERT(a_scan_bound, (state_reg != ST_SCAN) || (scan_idx_reg <= live_reg), "scan index ran past the live slot count")
    `PPSC_ASSERT(a_no_write_in_scan, !(mem_we && (state_reg == ST_SCAN)), "slot memory written while a scan reads it")
    `PPSC_ASSERT(a_result_from_finish, !$rose(out_valid_reg) || $past(state_reg == ST_FINISH), "result raised outside the finish state")
    `PPSC_ASSERT_NEXT(a_tick_starts_scan, accept && (in_item.func == FUNC_TICK), (state_reg == ST_SCAN) && (scan_idx_reg == '0), "tick did not start a scan")
    `PPSC_ASSERT(a_idle_result, !(out_valid_reg && out_item_reg.idle) || (!out_item_reg.finished && (out_item_reg.ran_id == 8'd0)), "idle result carries a job")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the preemptive priority scheduler core
// Drives load, tick and restart transactions with random gaps and
// back-pressure. A scoreboard predicts every tick result and checks it.
// ----------------------------------------------------------------------------
module tb;
    import ppsc_pkg::*;

    localparam int         SLOT_COUNT     = 16;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    // Cycles waited after the last result has appeared, so that the block is at
    // rest before active_count is written.
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         TARGET_ITEMS   = 1900;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow copy of the slot table, the time counter and the
    // active_count register. Each accepted tick pushes its expected result,
    // and each result taken from the block is checked against the oldest one.
    // ------------------------------------------------------------------------
    class sched_scoreboard;
        bit [7:0]  job_tab      [SLOT_COUNT];
        bit [7:0]  prio_tab     [SLOT_COUNT];
        bit [31:0] arrival_tab  [SLOT_COUNT];
        bit [15:0] work_tab     [SLOT_COUNT];
        bit        done_tab     [SLOT_COUNT];
        bit [31:0] sched_time;
        bit [4:0]  active_reg;
        out_item_t expected_ticks [$];
        int        errors;

        function void set_active(bit [4:0] value);
            active_reg = value;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function void note_input(in_item_t item);
            int        live;
            bit        found;
            int        best;
            out_item_t res;
            live = (active_reg > SLOT_COUNT) ? SLOT_COUNT : int'(active_reg);
            case (item.func)
                FUNC_LOAD:
                begin
                    job_tab[item.slot]     = item.job_id;
                    prio_tab[item.slot]    = item.priority_req;
                    arrival_tab[item.slot] = item.arrival;
                    work_tab[item.slot]    = item.work;
                    done_tab[item.slot]    = (item.work == 16'd0);
                end
                FUNC_RESTART:
                begin
                    sched_time = '0;
                    foreach (done_tab[i])
                        done_tab[i] = 1'b0;
                end
                FUNC_TICK:
                begin
                    found = 1'b0;
                    best  = 0;
                    for (int i = 0; i < live; i++)
                    begin
                        if (!done_tab[i] && arrival_tab[i] <= sched_time &&
                            (!found || prio_tab[i] > prio_tab[best]))
                        begin
                            found = 1'b1;
                            best  = i;
                        end
                    end
                    res           = '0;
                    res.tick_time = sched_time;
                    res.idle      = !found;
                    if (found)
                    begin
                        res.ran_id   = job_tab[best];
                        res.ran_slot = best[3:0];
                        if (work_tab[best] > 16'd1)
                            work_tab[best] = work_tab[best] - 16'd1;
                        else
                        begin
                            work_tab[best] = '0;
                            done_tab[best] = 1'b1;
                            res.finished   = 1'b1;
                        end
                    end
                    sched_time   = sched_time + 32'd1;
                    res.all_done = 1'b1;
                    for (int i = 0; i < live; i++)
                        if (!done_tab[i])
                            res.all_done = 1'b0;
                    expected_ticks.push_back(res);
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_ticks.size() == 0)
            begin
                $error("tick result with no tick outstanding");
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            if (got.ran_id !== want.ran_id)
            begin
                $error("ran_id: expected %0d, got %0d", want.ran_id, got.ran_id);
                errors++;
            end
            if (got.ran_slot !== want.ran_slot)
            begin
                $error("ran_slot: expected %0d, got %0d", want.ran_slot, got.ran_slot);
                errors++;
            end
            if (got.idle !== want.idle)
            begin
                $error("idle: expected %0d, got %0d", want.idle, got.idle);
                errors++;
            end
            if (got.tick_time !== want.tick_time)
            begin
                $error("tick_time: expected %0d, got %0d", want.tick_time, got.tick_time);
                errors++;
            end
            if (got.finished !== want.finished)
            begin
                $error("finished: expected %0d, got %0d", want.finished, got.finished);
                errors++;
            end
            if (got.all_done !== want.all_done)
            begin
                $error("all_done: expected %0d, got %0d", want.all_done, got.all_done);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;

    sched_scoreboard sb;
    // When set, the corresponding side runs without idling for a stretch.
    bit          quiet_tx;
    bit          quiet_rx;
    int          sent_items;
    int          quiet_cycles = 0;

    preemptive_priority_scheduler_core #(
        .NUM_SLOTS (SLOT_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: any stretch this long without a single transaction on either
    // channel means the block has hung, so the run is abandoned.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side. For every result a random number of stall cycles is drawn
    // first; stall is then released and held low until a transaction has
    // completed, which is checked at that rising edge.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            hold = quiet_rx ? 0 : $urandom_range(0, 16);
            if (hold > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_result(out_item);
        end
    end

    // Every field random, so that the bits a given operation ignores toggle
    // as well; callers then overwrite what matters.
    function automatic in_item_t scatter(logic [1:0] func);
        in_item_t item;
        item.func         = func;
        item.slot         = 4'($urandom_range(0, 15));
        item.job_id       = 8'($urandom_range(0, 255));
        item.work         = 16'($urandom_range(0, 65535));
        item.priority_req = 8'($urandom_range(0, 255));
        item.arrival      = $urandom();
        return item;
    endfunction

    function automatic in_item_t load_item(bit [3:0] slot, bit [7:0] job_id,
                                           bit [15:0] work, bit [7:0] prio,
                                           bit [31:0] arrival);
        in_item_t item;
        item              = scatter(FUNC_LOAD);
        item.slot         = slot;
        item.job_id       = job_id;
        item.work         = work;
        item.priority_req = prio;
        item.arrival      = arrival;
        return item;
    endfunction

    // A load shaped for a realistic schedule: short bursts, arrivals close to
    // the start of the run and, for half of the loads, a narrow priority band so
    // that ties happen, with a minority of extreme values mixed in.
    function automatic in_item_t job_load(int live);
        in_item_t item;
        int       pick;
        item = scatter(FUNC_LOAD);
        if (live > 0 && $urandom_range(0, 6) != 0)
            item.slot = 4'($urandom_range(0, live - 1));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            item.work = 16'($urandom_range(1, 6));
        else if (pick == 7)
            item.work = '0;
        else if (pick == 8)
            item.work = 16'($urandom_range(7, 40));
        pick = $urandom_range(0, 19);
        if (pick < 15)
            item.arrival = $urandom_range(0, 15);
        else if (pick < 18)
            item.arrival = $urandom_range(16, 60);
        if ($urandom_range(0, 1) == 0)
            item.priority_req = 8'($urandom_range(0, 3));
        return item;
    endfunction

    // Presents one transaction after a random gap and returns once it has
    // been accepted. Valid stays high afterwards, so that back-to-back
    // transactions need only one change at the next falling edge.
    task automatic send_item(input in_item_t item);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(item);
        if (item.func != FUNC_UNUSED)
            sent_items++;
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Brings the block to rest: no transaction offered, nothing outstanding,
    // and enough further cycles for a load or restart still in flight.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_active(input bit [4:0] value);
        settle();
        @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_active(value);
    endtask

    initial
    begin
        int pick;
        int cfg_value;
        int live;
        int loads;
        int ticks;

        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        quiet_tx   = 1'b0;
        quiet_rx   = 1'b0;
        sent_items = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. With no active slots straight after reset a tick is
        // idle and reports everything done; the unused operation code must
        // leave no trace.
        send_item(scatter(FUNC_TICK));
        send_item(scatter(FUNC_UNUSED));

        // Fill every slot before any slot takes part, so that no scan ever
        // reads an entry that was never written. Slot 0 and slot 15 tie on
        // the top priority, slot 1 has zero work and is complete at once,
        // slot 2 holds the longest burst and slot 3 arrives at the very end
        // of the time range.
        send_item(load_item(4'd0, 8'd255, 16'd1, 8'd255, 32'd0));
        send_item(load_item(4'd1, 8'd0, 16'd0, 8'd255, 32'd0));
        send_item(load_item(4'd2, 8'd17, 16'hFFFF, 8'd0, 32'd0));
        send_item(load_item(4'd3, 8'd90, 16'd3, 8'd200, 32'hFFFF_FFFF));
        for (int s = 4; s < 15; s++)
            send_item(load_item(4'(s), 8'($urandom_range(0, 255)),
                                16'($urandom_range(1, 6)),
                                8'($urandom_range(0, 254)),
                                $urandom_range(0, 8)));
        send_item(load_item(4'd15, 8'd170, 16'd2, 8'd255, 32'd1));

        write_active(5'd16);
        // Slot 0 wins the tie with slot 15 and finishes; slot 15 runs on the next tick.
        send_item(scatter(FUNC_TICK));
        send_item(scatter(FUNC_TICK));
        // After a restart slot 0 is picked again with no work left: it still
        // reports finished and becomes complete once more.
        send_item(scatter(FUNC_RESTART));
        send_item(scatter(FUNC_TICK));
        // Counts above the table size behave as the full table.
        write_active(5'd31);
        send_item(scatter(FUNC_TICK));
        write_active(5'd0);
        send_item(scatter(FUNC_TICK));

        // Random part. Each phase sets a slot count, restarts, loads a batch
        // of jobs and then ticks through them. Late loads preempt the running
        // job, and restarts, unused codes and sender pauses are mixed in.
        while (sent_items < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                cfg_value = 0;
            else if (pick == 1)
                cfg_value = 16;
            else if (pick == 2)
                cfg_value = $urandom_range(17, 31);
            else
                cfg_value = $urandom_range(1, 16);
            write_active(5'(cfg_value));
            live     = (cfg_value > SLOT_COUNT) ? SLOT_COUNT : cfg_value;
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);

            send_item(scatter(FUNC_RESTART));
            loads = $urandom_range(1, live + 1);
            for (int k = 0; k < loads; k++)
                send_item(job_load(live));

            ticks = $urandom_range(4, 40);
            for (int k = 0; k < ticks; k++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_item(scatter(FUNC_UNUSED));
                else if (pick == 1)
                    send_item(job_load(live));
                else if (pick == 2 && $urandom_range(0, 3) == 0)
                    send_item(scatter(FUNC_RESTART));
                else
                begin
                    if (pick == 3 && $urandom_range(0, 3) == 0)
                    begin
                        // The sender holds off until every tick so far has
                        // been answered.
                        @(negedge clk);
                        in_valid <= 1'b0;
                        wait_for_results();
                    end
                    send_item(scatter(FUNC_TICK));
                end
            end
        end

        quiet_rx = 1'b0;
        settle();
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/ppsc_pkg.sv
design/ppsc_slot_mem.sv
design/ppsc_pick.sv
design/preemptive_priority_scheduler_core.sv
sim/tb.sv
